// ===== rtl/http_chunked_body_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// HTTP chunked body decoder assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define HCBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HCBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Parser phase codes, status codes, character constants and hex decoding.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Position in the chunked grammar, one-hot.
    typedef enum logic [7:0] {
        PH_BLANK    = 8'b0000_0001,
        PH_DIGITS   = 8'b0000_0010,
        PH_IGNORE   = 8'b0000_0100,
        PH_LF_BLANK = 8'b0000_1000,
        PH_LF_TEXT  = 8'b0001_0000,
        PH_DATA     = 8'b0010_0000,
        PH_DATA_CR  = 8'b0100_0000,
        PH_DATA_LF  = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_DONE  = 2'd1,
        ST_PROTO = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    // Bits per hex digit (radix 16).
    localparam int HEX_BITS = 4;

    typedef struct packed {
        logic                ok;
        logic [HEX_BITS-1:0] val;
    } hex_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] payload;
        logic       data_valid;
    } result_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b1;
        h.val = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Decodes an HTTP/1.1 chunked message body one byte per word. Every input
// word (in_byte in s_tdata, is_final on s_tlast) yields exactly one result
// word: m_tdata carries the payload byte and m_tuser carries data_valid in
// bit 0 and the sticky status in bits 2:1 (0 running, 1 done, 2 protocol
// error, 3 overflow error). Size lines skip leading blanks, gather hex digits
// and ignore any extension text up to CR LF; a zero or digitless size ends
// decoding, after which bytes are consumed and the final status repeats. The
// block sustains one word per clock while m_tready is high, and each result
// is registered; the grammar state and size counter update once per byte, and
// a two-entry output stage (result register plus skid register) lets input
// continue for one word while the result side is stalled. s_tready is driven
// from a register and depends only on whether the skid entry is occupied.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_assert.svh"

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser    // [0] data_valid, [2:1] status
);
    import hcbd_pkg::*;

    // Parser state.
    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] rem_reg,   rem_next;
    status_t              fin_reg,   fin_next;

    // Output stage.
    result_t result_next;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic                 in_acc, out_take;
    hex_t                 hex;
    logic [SIZE_BITS-1:0] rem_dec;

    assign s_tready = !skid_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    assign hex     = hex_decode(s_tdata);
    assign rem_dec = rem_reg - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // One grammar step per byte.
    always_comb begin
        phase_next             = phase_reg;
        rem_next               = rem_reg;
        fin_next               = fin_reg;
        result_next.data_valid = 1'b0;
        result_next.payload    = '0;
        if (fin_reg == ST_RUN) begin
            unique case (phase_reg)
                // A CR seen while skipping blanks behaves just like a fresh
                // blank-phase byte unless LF follows, so both share one arm.
                PH_BLANK, PH_LF_BLANK: begin
                    if (phase_reg == PH_LF_BLANK && s_tdata == CH_LF) begin
                        if (rem_reg == '0) fin_next = ST_DONE;
                        else               phase_next = PH_DATA;
                    end else if (s_tdata == CH_CR) begin
                        phase_next = PH_LF_BLANK;
                    end else if (is_blank(s_tdata)) begin
                        phase_next = PH_BLANK;
                    end else if (hex.ok) begin
                        rem_next   = {{(SIZE_BITS-HEX_BITS){1'b0}}, hex.val};
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_DIGITS: begin
                    if (s_tdata == CH_CR) begin
                        phase_next = PH_LF_TEXT;
                    end else if (hex.ok) begin
                        // Another digit would push bits off the top: saturate.
                        if (|rem_reg[SIZE_BITS-1:SIZE_BITS-HEX_BITS]) begin
                            rem_next = '1;
                            fin_next = ST_OVER;
                        end else begin
                            rem_next = {rem_reg[SIZE_BITS-HEX_BITS-1:0], hex.val};
                        end
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_IGNORE: begin
                    if (s_tdata == CH_CR) phase_next = PH_LF_TEXT;
                end
                PH_LF_TEXT: begin
                    if (s_tdata == CH_LF) begin
                        if (rem_reg == '0) fin_next = ST_DONE;
                        else               phase_next = PH_DATA;
                    end else if (s_tdata != CH_CR) begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_DATA: begin
                    result_next.data_valid = 1'b1;
                    result_next.payload    = s_tdata;
                    rem_next               = rem_dec;
                    if (rem_dec == '0) phase_next = PH_DATA_CR;
                end
                PH_DATA_CR: begin
                    if (s_tdata == CH_CR) phase_next = PH_DATA_LF;
                    else                  fin_next   = ST_PROTO;
                end
                PH_DATA_LF: begin
                    if (s_tdata == CH_LF) begin
                        phase_next = PH_BLANK;
                        rem_next   = '0;
                    end else begin
                        fin_next = ST_PROTO;
                    end
                end
                default: begin
                    fin_next = ST_PROTO;
                end
            endcase
            // The body ending before the terminating chunk is an error; it is
            // an overflow when payload bytes of the current chunk remain.
            if (s_tlast && fin_next == ST_RUN) begin
                fin_next = (phase_next == PH_DATA) ? ST_OVER : ST_PROTO;
            end
        end
        result_next.status = fin_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BLANK;
            rem_reg   <= '0;
            fin_reg   <= ST_RUN;
        end else if (in_acc) begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            fin_reg   <= fin_next;
        end
    end

    // Output register with a single skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_acc;
            end
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) out_reg <= skid_reg;
            else if (in_acc)    out_reg <= result_next;
        end else if (in_acc) begin
            skid_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.payload;
    assign m_tuser  = {out_reg.status, out_reg.data_valid};

    // The skid entry is only ever filled behind a held result.
    `HCBD_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid holds a word while output is empty")
    // Once finished, the status never changes.
    `HCBD_ASSERT_NXT(a_status_sticky, fin_reg != ST_RUN, fin_reg == $past(fin_reg), "finished status changed")
    // While streaming payload, at least one payload byte is still due.
    `HCBD_ASSERT_IMP(a_data_nonzero, fin_reg == ST_RUN && phase_reg == PH_DATA, rem_reg != '0, "data phase with zero bytes remaining")

endmodule
